@@ sv/assert_macros.svh @@
// Assertion macros shared by the hash table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define LPHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define LPHT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/lpht_pkg.sv @@
// Types, codes and constants of the linear probing hash table.
package lpht_pkg;

  localparam int TABLE_SIZE_DEF = 16;

  localparam int REQ_W      = 2;
  localparam int KEY_W      = 63;
  localparam int SEL_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int SLOT_IDX_W = 4;

  // The key is reduced modulo the table size one byte per cycle.
  localparam int MOD_DIGIT_W = 8;
  localparam int MOD_STEPS   = 8;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ      = 3'd4;

  typedef struct packed {
    logic in_ready;
    logic clear_we;
    logic mod_step;
    logic issue_home;
    logic issue_sel;
    logic probe_step;
    logic fin_probe;
    logic fin_read;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic             in_valid;
    logic [REQ_W-1:0] in_req;
    logic             clear_done;
    logic             mod_done;
    logic             probe_stop;
    logic             probe_last;
    logic             out_free;
  } sts_t;

endpackage

@@ sv/lpht_if.sv @@
// Request and response channel interfaces of the hash table.
interface lpht_req_if;
  import lpht_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key;
  logic [SEL_W-1:0] slot_sel;

  modport source (output valid, req_type, key, slot_sel, input ready);
  modport sink (input valid, req_type, key, slot_sel, output ready);
endinterface

interface lpht_rsp_if;
  import lpht_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [KEY_W-1:0]      slot_value;
  logic                  slot_empty;

  modport source (output valid, status, slot_index, slot_value, slot_empty, input ready);
  modport sink (input valid, status, slot_index, slot_value, slot_empty, output ready);
endinterface

@@ sv/lpht_datapath.sv @@
// Datapath: slot memory, modulo unit, probe pointer, result and output registers.
`include "assert_macros.svh"

module lpht_datapath #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  lpht_pkg::cmd_t cmd,
  output lpht_pkg::sts_t sts,
  lpht_req_if.sink       req,
  lpht_rsp_if.source     rsp
);
  import lpht_pkg::*;

  localparam int IW       = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int MCW      = $clog2(MOD_STEPS);
  localparam int MOD_SH_W = MOD_STEPS * MOD_DIGIT_W;
  localparam logic [IW:0]    SIZE_C = (IW + 1)'(TABLE_SIZE);
  localparam logic [IW-1:0]  LAST_C = IW'(TABLE_SIZE - 1);

  logic [KEY_W-1:0] mem [TABLE_SIZE];
  logic [KEY_W-1:0] rdata;
  logic [IW-1:0]    raddr;
  logic [IW-1:0]    waddr;
  logic [KEY_W-1:0] wdata;
  logic             we;

  logic                  load;
  logic [REQ_W-1:0]      req_kind;
  logic [KEY_W-1:0]      key_q;
  logic [SEL_W-1:0]      sel_q;
  logic [MOD_SH_W-1:0]   mod_sh;
  logic [IW-1:0]         mod_rem;
  logic [IW-1:0]         mod_rem_next;
  logic [IW:0]           rem_t;
  logic [MCW-1:0]        mod_cnt;
  logic [IW-1:0]         probe;
  logic [IW-1:0]         probe_inc;
  logic [IW-1:0]         probe_cnt;
  logic [IW-1:0]         clear_cnt;
  logic [31:0]           sel_wide;
  logic [31:0]           probe_wide;
  logic [IW-1:0]         sel_addr;
  logic                  sel_ok;
  logic [SLOT_IDX_W-1:0] probe_idx;
  logic                  is_empty;
  logic                  is_match;
  logic                  probe_stop;
  logic [KEY_W-1:0]      read_value;

  logic [STATUS_W-1:0]   res_status;
  logic [SLOT_IDX_W-1:0] res_idx;
  logic [KEY_W-1:0]      res_value;
  logic                  res_empty;
  logic                  out_valid;
  logic                  out_free;

  assign load      = req.valid && cmd.in_ready;
  assign req.ready = cmd.in_ready;

  // Remainder update for one byte of the key, most significant bit first.
  always_comb begin
    rem_t = {1'b0, mod_rem};
    for (int i = 0; i < MOD_DIGIT_W; i++) begin
      rem_t = {rem_t[IW-1:0], mod_sh[MOD_SH_W-1-i]};
      if (rem_t >= SIZE_C) begin
        rem_t = rem_t - SIZE_C;
      end
    end
    mod_rem_next = rem_t[IW-1:0];
  end

  assign sel_wide   = 32'(sel_q);
  assign sel_addr   = sel_wide[IW-1:0];
  assign sel_ok     = sel_wide < 32'(TABLE_SIZE);
  assign probe_inc  = (probe == LAST_C) ? '0 : probe + IW'(1);
  assign probe_wide = 32'(probe);
  assign probe_idx  = probe_wide[SLOT_IDX_W-1:0];
  assign is_empty   = (rdata == '0);
  assign is_match   = (rdata == key_q);
  assign probe_stop = (req_kind == REQ_INSERT) ? is_empty : (is_match || is_empty);
  assign read_value = sel_ok ? rdata : '0;

  always_comb begin
    if (cmd.issue_home) begin
      raddr = mod_rem;
    end else if (cmd.issue_sel) begin
      raddr = sel_addr;
    end else begin
      raddr = probe_inc;
    end
  end

  assign we    = cmd.clear_we || (cmd.fin_probe && (req_kind == REQ_INSERT) && is_empty);
  assign waddr = cmd.clear_we ? clear_cnt : probe;
  assign wdata = cmd.clear_we ? '0 : key_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (cmd.clear_we) begin
      clear_cnt <= (clear_cnt == LAST_C) ? '0 : clear_cnt + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_kind <= req.req_type;
      key_q    <= req.key;
      sel_q    <= req.slot_sel;
      mod_sh   <= MOD_SH_W'(req.key);
      mod_rem  <= '0;
      mod_cnt  <= '0;
    end else if (cmd.mod_step) begin
      mod_sh  <= mod_sh << MOD_DIGIT_W;
      mod_rem <= mod_rem_next;
      mod_cnt <= mod_cnt + MCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe     <= '0;
      probe_cnt <= '0;
    end else if (cmd.issue_home) begin
      probe     <= mod_rem;
      probe_cnt <= '0;
    end else if (cmd.probe_step) begin
      probe     <= probe_inc;
      probe_cnt <= probe_cnt + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_probe) begin
      res_value <= '0;
      res_empty <= 1'b0;
      if (req_kind == REQ_INSERT) begin
        res_status <= is_empty ? ST_INSERTED : ST_FULL;
        res_idx    <= is_empty ? probe_idx : '0;
      end else begin
        res_status <= is_match ? ST_FOUND : ST_NOT_FOUND;
        res_idx    <= is_match ? probe_idx : '0;
      end
    end else if (cmd.fin_read) begin
      res_status <= ST_READ;
      res_idx    <= sel_q;
      res_value  <= read_value;
      res_empty  <= (read_value == '0);
    end
  end

  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status     <= res_status;
      rsp.slot_index <= res_idx;
      rsp.slot_value <= res_value;
      rsp.slot_empty <= res_empty;
    end
  end

  assign rsp.valid = out_valid;

  assign sts.in_valid   = req.valid;
  assign sts.in_req     = req.req_type;
  assign sts.clear_done = (clear_cnt == LAST_C);
  assign sts.mod_done   = (mod_cnt == MCW'(MOD_STEPS - 1));
  assign sts.probe_stop = probe_stop;
  assign sts.probe_last = (probe_cnt == LAST_C);
  assign sts.out_free   = out_free;

  `LPHT_ASSERT(a_probe_in_range, 32'(probe_cnt) < 32'(TABLE_SIZE), "probe count out of range")
  `LPHT_ASSERT(a_out_rise_on_emit, $rose(out_valid) |-> $past(cmd.emit), "output valid without emit")

endmodule

@@ sv/lpht_ctrl.sv @@
// Controller state machine that sequences clearing, modulo, probing and output.
`include "assert_macros.svh"

module lpht_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t cmd
);
  import lpht_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_RSEL  = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          // An unused request code is taken and dropped without a result.
          unique case (sts.in_req) inside
            REQ_INSERT, REQ_SEARCH: state_next = S_MOD;
            REQ_READ:               state_next = S_RSEL;
            default:                state_next = S_IDLE;
          endcase
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue_home = 1'b1;
        state_next     = S_PROBE;
      end
      S_PROBE: begin
        if (sts.probe_stop || sts.probe_last) begin
          cmd.fin_probe = 1'b1;
          state_next    = S_EMIT;
        end else begin
          cmd.probe_step = 1'b1;
        end
      end
      S_RSEL: begin
        cmd.issue_sel = 1'b1;
        state_next    = S_READ;
      end
      S_READ: begin
        cmd.fin_read = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  `LPHT_ASSERT(a_reset_clears, $past(rst) |-> (state == S_CLEAR), "no clearing pass after reset")
  `LPHT_ASSERT(a_emit_free, cmd.emit |-> sts.out_free, "result emitted over a waiting item")

endmodule

@@ sv/linear_probing_hash_table_top.sv @@
// Insert and search reduce the key to a home slot, then make p probes (1..TABLE_SIZE) before the result.
// The modulo unit finds the home slot; the memory read port then reads one slot a cycle.
// Read requests read the selected slot directly; one item is in work at a time, overlapping a waiting result.
// Reset is synchronous; afterwards a clearing pass empties the table slot by slot.
// No item is accepted during the clearing pass.
module linear_probing_hash_table_top #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input logic        clk,
  input logic        rst,
  lpht_req_if.sink   req,
  lpht_rsp_if.source rsp
);
  import lpht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lpht_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  lpht_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

endmodule

@@ bench/lpht_checker.sv @@
// Checker that predicts hash table results from the request channel and compares them.
`timescale 1ns / 1ps

module lpht_checker #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic clk,
  input  logic rst,
  lpht_req_if  req,
  lpht_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);
  import lpht_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [KEY_W-1:0]      slot_value;
    logic                  slot_empty;
  } table_rsp_t;

  logic [KEY_W-1:0] shadow_slots [TABLE_SIZE];
  table_rsp_t       expected_rsp_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic table_rsp_t probe_table(input logic [REQ_W-1:0] req_type,
                                             input logic [KEY_W-1:0] key,
                                             input logic [SEL_W-1:0] sel);
    table_rsp_t       r;
    int               probe;
    logic [KEY_W-1:0] v;
    r     = '0;
    probe = int'(key % KEY_W'(TABLE_SIZE));
    case (req_type)
      REQ_INSERT: begin
        r.status = ST_FULL;
        for (int n = 0; n < TABLE_SIZE; n++) begin
          if (shadow_slots[probe] == '0) begin
            shadow_slots[probe] = key;
            r.status     = ST_INSERTED;
            r.slot_index = probe[SLOT_IDX_W-1:0];
            return r;
          end
          probe = (probe + 1) % TABLE_SIZE;
        end
      end
      REQ_SEARCH: begin
        r.status = ST_NOT_FOUND;
        for (int n = 0; n < TABLE_SIZE; n++) begin
          if (shadow_slots[probe] == key) begin
            r.status     = ST_FOUND;
            r.slot_index = probe[SLOT_IDX_W-1:0];
            return r;
          end
          if (shadow_slots[probe] == '0) return r;
          probe = (probe + 1) % TABLE_SIZE;
        end
      end
      default: begin
        // A slot beyond the table reads as empty.
        v = '0;
        if (int'(sel) < TABLE_SIZE) v = shadow_slots[sel];
        r.status     = ST_READ;
        r.slot_index = sel;
        r.slot_value = v;
        r.slot_empty = (v == '0);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    table_rsp_t want;
    table_rsp_t got;
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) shadow_slots[i] = '0;
      expected_rsp_q.delete();
    end else begin
      // Results belong to earlier items, so they are checked before the new item is predicted.
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.slot_index, rsp.slot_value, rsp.slot_empty};
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d index=%0d value=%h empty=%0d",
                   $time, got.status, got.slot_index, got.slot_value, got.slot_empty);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_rsp_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected status=%0d index=%0d value=%h empty=%0d",
                     $time, want.status, want.slot_index, want.slot_value, want.slot_empty);
            $display("%0t:                   actual status=%0d index=%0d value=%h empty=%0d",
                     $time, got.status, got.slot_index, got.slot_value, got.slot_empty);
            fail_count <= fail_count + 1;
          end
        end
      end
      // The unused request code produces no result.
      if (req.valid && req.ready && (req.req_type == REQ_INSERT ||
          req.req_type == REQ_SEARCH || req.req_type == REQ_READ))
        expected_rsp_q.push_back(probe_table(req.req_type, req.key, req.slot_sel));
    end
    pending <= expected_rsp_q.size();
  end

endmodule

@@ bench/tb_linear_probing_hash_table_top.sv @@
// Testbench top: clock, reset, request stimulus, response stalls and the final verdict.
`timescale 1ns / 1ps

module tb_linear_probing_hash_table_top;
  import lpht_pkg::*;

  localparam int TABLE_SIZE = TABLE_SIZE_DEF;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   burst_left;
  int   ready_mode;
  int   ready_phase;

  logic [KEY_W-1:0] stored_keys [$];

  lpht_req_if req_ch ();
  lpht_rsp_if rsp_ch ();

  linear_probing_hash_table_top #(
    .TABLE_SIZE(TABLE_SIZE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  lpht_checker #(
    .TABLE_SIZE(TABLE_SIZE)
  ) table_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_INSERT;
    req_ch.key       = '0;
    req_ch.slot_sel  = '0;
    rsp_ch.ready     = 1'b0;
    cycle_count      = 0;
    burst_left       = 0;
    ready_mode       = 0;
    ready_phase      = 0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The receiver switches between always ready, random stalls and a fixed stall pattern.
  always @(negedge clk) begin
    ready_phase <= ready_phase + 1;
    if (ready_phase % 97 == 0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0:       rsp_ch.ready <= 1'b1;
      1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      default: rsp_ch.ready <= ((ready_phase % 7) < 3);
    endcase
  end

  function automatic logic [KEY_W-1:0] random_key();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[KEY_W-1:0];
  endfunction

  // Drives one item at the falling edge and holds it until the block takes it.
  task automatic send_request(input logic [REQ_W-1:0] req_type,
                              input logic [KEY_W-1:0] key,
                              input logic [SEL_W-1:0] sel);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= req_type;
    req_ch.key      <= key;
    req_ch.slot_sel <= sel;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  initial begin
    int               items;
    int               pick;
    logic [KEY_W-1:0] k;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table: reads, misses, and the zero key found in its home slot.
    send_request(REQ_READ, random_key(), 4'd0);
    send_request(REQ_SEARCH, KEY_W'(5), 4'd9);
    send_request(REQ_SEARCH, '0, 4'd0);
    // Inserting the zero key leaves the table unchanged.
    send_request(REQ_INSERT, '0, 4'd15);
    send_request(REQ_INSERT, KEY_MAX, 4'd0);
    // Collides with the maximum key in the last slot and wraps to slot 0.
    send_request(REQ_INSERT, KEY_W'(31), 4'd0);
    // A duplicate is stored again.
    send_request(REQ_INSERT, KEY_W'(31), 4'd0);
    send_request(REQ_SEARCH, KEY_W'(31), 4'd0);
    send_request(REQ_SEARCH, KEY_W'(47), 4'd0);
    send_request(REQ_SEARCH, '0, 4'd0);
    send_request(REQ_READ, random_key(), 4'd15);
    send_request(REQ_UNUSED, random_key(), 4'd3);
    stored_keys.push_back(KEY_MAX);
    stored_keys.push_back(KEY_W'(31));
    // Keys sharing one home slot fill the rest of the table with long probe runs.
    for (int i = 0; i < TABLE_SIZE - 3; i++) begin
      k      = random_key();
      k[3:0] = 4'd3;
      stored_keys.push_back(k);
      send_request(REQ_INSERT, k, 4'(i));
    end
    // Full table: insert fails, and a miss or the zero key runs one full pass.
    send_request(REQ_INSERT, KEY_W'(7), 4'd0);
    k      = random_key();
    k[3:0] = 4'd8;
    send_request(REQ_SEARCH, k, 4'd0);
    send_request(REQ_SEARCH, '0, 4'd0);

    items = 0;
    while (items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       k = '0;
        1:       k = KEY_MAX;
        2, 3, 4: k = (stored_keys.size() > 0) ?
                     stored_keys[$urandom_range(0, stored_keys.size() - 1)] : random_key();
        default: k = random_key();
      endcase
      if (pick < 15) begin
        if (k != '0) stored_keys.push_back(k);
        send_request(REQ_INSERT, k, 4'($urandom));
        items++;
      end else if (pick < 60) begin
        // Most searches look for a key that an insert has sent before.
        if ($urandom_range(0, 1) == 0 && stored_keys.size() > 0)
          k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        send_request(REQ_SEARCH, k, 4'($urandom));
        items++;
      end else if (pick < 95) begin
        send_request(REQ_READ, k, 4'($urandom_range(0, 15)));
        items++;
      end else begin
        send_request(REQ_UNUSED, k, 4'($urandom));
      end
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
